/* hw/rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands. The using scope provides clk_i
// and rst_ni.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hw/rtl/aic_pkg.sv */
// ---------------------------------------------------------------------------
// Instruction classifier package
// Handler class codes and field widths shared by the classifier modules.
// ---------------------------------------------------------------------------
package aic_pkg;

  localparam int unsigned InstrWidth = 32;
  localparam int unsigned ClassWidth = 5;

  typedef enum logic [ClassWidth-1:0] {
    HC_UNDEF      = 5'd0,
    HC_UNIMPL     = 5'd1,
    HC_DATA_PROC  = 5'd2,
    HC_MRS        = 5'd3,
    HC_MSR        = 5'd4,
    HC_BX         = 5'd5,
    HC_CLZ        = 5'd6,
    HC_BKPT       = 5'd7,
    HC_MUL        = 5'd8,
    HC_MULL       = 5'd9,
    HC_SWAP       = 5'd10,
    HC_EXCL       = 5'd11,
    HC_EXTRA_LS   = 5'd12,
    HC_LOAD_STORE = 5'd13,
    HC_EXTEND     = 5'd14,
    HC_BITFIELD   = 5'd15,
    HC_LS_MULTI   = 5'd16,
    HC_BRANCH     = 5'd17,
    HC_MCRR       = 5'd18,
    HC_COP_LS     = 5'd19,
    HC_COP_REG    = 5'd20,
    HC_COP_DP     = 5'd21,
    HC_SWI        = 5'd22,
    HC_CPS        = 5'd23,
    HC_HINT       = 5'd24,
    HC_PRELOAD    = 5'd25,
    HC_SRS        = 5'd26,
    HC_RFE        = 5'd27
  } handler_class_e;

endpackage

/* hw/rtl/aic_stage.sv */
// ---------------------------------------------------------------------------
// Classifier pipeline stage
// One valid/ready register slice; it refills in the cycle it drains.
// ---------------------------------------------------------------------------
module aic_stage #(
  parameter int unsigned Width = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [Width-1:0] data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [Width-1:0] data_o
);

  logic             valid_d, valid_q;
  logic [Width-1:0] data_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* hw/rtl/aic_decode.sv */
// ---------------------------------------------------------------------------
// Instruction class decoder
// Mask-and-compare decode of one A32 word into its handler class.
// ---------------------------------------------------------------------------
module aic_decode import aic_pkg::*; (
  input  logic [InstrWidth-1:0] instr_i,
  input  logic                  arch_v6_i,
  output handler_class_e        class_o
);

  // Miscellaneous group: status moves, branch-exchange, clz, bkpt.
  function automatic handler_class_e cls_misc(input logic [31:0] w);
    handler_class_e r;
    logic [1:0] o;
    o = w[22:21];
    r = HC_UNDEF;
    case (w[6:4])
      3'd0: begin
        if (w[9]) r = HC_UNIMPL;
        else if (!o[0]) r = HC_MRS;
        else if (o == 2'd1) r = HC_MSR;
      end
      3'd1: begin
        if (o == 2'd1) r = HC_BX;
        else if (o == 2'd3) r = HC_CLZ;
      end
      3'd2: if (o == 2'd1) r = HC_UNIMPL;
      3'd3: if (o == 2'd1) r = HC_BX;
      3'd5: r = HC_UNIMPL;
      3'd6: if (o == 2'd3) r = HC_UNIMPL;
      3'd7: begin
        if (o == 2'd1) r = HC_BKPT;
        else if (o[1]) r = HC_UNIMPL;
      end
      default: r = HC_UNDEF;
    endcase
    return r;
  endfunction

  // Data-processing and miscellaneous space (bits 27:25 all zero).
  function automatic handler_class_e cls_group0(input logic [31:0] w);
    handler_class_e r;
    logic [4:0] p1;
    logic [3:0] p2;
    logic [3:0] m;
    p1 = w[24:20];
    p2 = w[7:4];
    m  = p1[3:0];
    r  = HC_UNDEF;
    if ((p1 & 5'b11001) == 5'b10000) begin
      if (!p2[3]) r = cls_misc(w);
      else if ((p2 & 4'b1001) == 4'b1000) r = HC_UNIMPL;
    end else if (!p2[0] || (p2 & 4'b1001) == 4'b0001) begin
      r = HC_DATA_PROC;
    end else if (!p1[4] && p2 == 4'b1001) begin
      if (m[3:1] == 3'd0 || m[3:1] == 3'd1 || m == 4'd6) r = HC_MUL;
      else if (m == 4'd4) r = HC_UNIMPL;
      else if (m[3]) r = HC_MULL;
    end else if (p2 == 4'b1001) begin
      r = ((m & 4'b1011) == 4'd0) ? HC_SWAP : HC_EXCL;
    end else if ((p1 & 5'b10011) == 5'b00010 && (p2 & 4'b1101) == 4'b1101) begin
      r = HC_EXTRA_LS;
    end else if ((p1 & 5'b10010) == 5'b00010 && p2 == 4'b1011) begin
      r = HC_UNIMPL;
    end else if ((p1 & 5'b10011) == 5'b00011 && (p2 & 4'b1101) == 4'b1101) begin
      r = HC_UNIMPL;
    end else if (p2 == 4'b1011 || (p2 & 4'b1101) == 4'b1101) begin
      r = HC_EXTRA_LS;
    end
    return r;
  endfunction

  // Packing, unpacking, saturation and reversal sub-group of media.
  function automatic handler_class_e cls_pack(input logic [31:0] w);
    handler_class_e r;
    logic [2:0] p2;
    p2 = w[7:5];
    r  = HC_UNDEF;
    case (w[22:20])
      3'd0: begin
        if (!p2[0]) r = HC_UNIMPL;
        else if (p2 == 3'd3) r = HC_EXTEND;
        else if (p2 == 3'd5) r = HC_UNIMPL;
      end
      3'd2, 3'd6: begin
        if (p2 == 3'd1) r = HC_UNIMPL;
        else if (p2 == 3'd3) r = HC_EXTEND;
        else if (!p2[0]) r = HC_UNIMPL;
      end
      3'd3, 3'd7: begin
        if (p2 == 3'd1 || p2 == 3'd5) r = HC_UNIMPL;
        else if (p2 == 3'd3) r = HC_EXTEND;
        else if (!p2[0]) r = HC_UNIMPL;
      end
      3'd4: if (p2 == 3'd3) r = HC_EXTEND;
      default: r = HC_UNDEF;
    endcase
    return r;
  endfunction

  // Media group; only present on v6 and later cores.
  function automatic handler_class_e cls_media(input logic [31:0] w, input logic v6);
    handler_class_e r;
    logic [4:0] p1;
    logic [2:0] p2;
    p1 = w[24:20];
    p2 = w[7:5];
    if (!v6) r = HC_UNDEF;
    else if (p1[4:3] == 2'b00) r = HC_UNIMPL;
    else if (p1[4:3] == 2'b01) r = cls_pack(w);
    else if (p1[4:3] == 2'b10) r = HC_UNIMPL;
    else if (p1 == 5'b11000 && p2 == 3'd0) r = HC_UNIMPL;
    else if ((p1 & 5'b11010) == 5'b11010 && p2[1:0] == 2'b10) r = HC_BITFIELD;
    else if ((p1 & 5'b11110) == 5'b11100 && p2[1:0] == 2'b00) r = HC_UNIMPL;
    else if (p1 == 5'b11111 && p2 == 3'd7) r = HC_UNDEF;
    else r = HC_UNIMPL;
    return r;
  endfunction

  // Unconditional space with bit 27 clear: cps, hints, preload.
  function automatic handler_class_e cls_uncond_hint(input logic [31:0] w);
    handler_class_e r;
    logic [6:0] p1;
    logic [3:0] p2;
    logic       rn0;
    logic       even;
    p1   = w[26:20];
    p2   = w[7:4];
    rn0  = w[16];
    even = !p2[0];
    r    = HC_UNDEF;
    if (p1 == 7'h10) begin
      if (!p2[1] && !rn0) r = HC_CPS;
      else if (p2 == 4'd0 && rn0) r = HC_UNIMPL;
    end else if ((p1 & 7'h60) == 7'h20) begin
      r = HC_UNIMPL;
    end else if ((p1 & 7'h71) == 7'h40) begin
      r = HC_UNIMPL;
    end else if ((p1 & 7'h77) == 7'h41) begin
      r = HC_HINT;
    end else if ((p1 & 7'h77) == 7'h45 || (p1 & 7'h77) == 7'h51 ||
                 (p1 & 7'h77) == 7'h55) begin
      r = HC_PRELOAD;
    end else if (p1 == 7'h57) begin
      if (p2 == 4'd1 || p2 == 4'd4 || p2 == 4'd5 || p2 == 4'd6) r = HC_HINT;
    end else if ((p1 & 7'h7B) == 7'h5B) begin
      r = HC_HINT;
    end else if (even && ((p1 & 7'h77) == 7'h65 || (p1 & 7'h77) == 7'h61 ||
                          (p1 & 7'h77) == 7'h75)) begin
      r = HC_PRELOAD;
    end
    return r;
  endfunction

  // Remaining unconditional space: srs, rfe, blx immediate, coprocessor.
  function automatic handler_class_e cls_uncond_other(input logic [31:0] w);
    handler_class_e r;
    logic [7:0] p1;
    p1 = w[27:20];
    if ((p1 & 8'hE5) == 8'h84) r = HC_SRS;
    else if ((p1 & 8'hE5) == 8'h81) r = HC_RFE;
    else if ((p1 & 8'hE0) == 8'hA0) r = HC_BRANCH;
    else if ((p1 & 8'hE0) == 8'hC0) r = HC_UNIMPL;
    else if ((p1 & 8'hF0) == 8'hE0) r = HC_UNIMPL;
    else r = HC_UNDEF;
    return r;
  endfunction

  function automatic handler_class_e classify(input logic [31:0] w, input logic v6);
    handler_class_e r;
    logic [4:0] p1;
    p1 = w[24:20];
    r  = HC_UNDEF;
    if (w[31:27] == 5'b11110) begin
      r = cls_uncond_hint(w);
    end else if (w[31:28] == 4'b1111) begin
      r = cls_uncond_other(w);
    end else begin
      case (w[27:25])
        3'd0: r = cls_group0(w);
        3'd1: begin
          // Immediate forms: msr immediate, and movw/movt on v6 and later.
          if (p1 == 5'h12 || p1 == 5'h16) r = HC_MSR;
          else if (p1 == 5'h10 || p1 == 5'h14) r = v6 ? HC_DATA_PROC : HC_UNDEF;
          else r = HC_DATA_PROC;
        end
        3'd2: r = HC_LOAD_STORE;
        3'd3: r = w[4] ? cls_media(w, v6) : HC_LOAD_STORE;
        3'd4: r = HC_LS_MULTI;
        3'd5: r = HC_BRANCH;
        3'd6: begin
          if (w[24:23] == 2'b00 && !w[21]) r = w[22] ? HC_MCRR : HC_UNDEF;
          else r = HC_COP_LS;
        end
        3'd7: begin
          if (w[24]) r = HC_SWI;
          else r = w[4] ? HC_COP_REG : HC_COP_DP;
        end
        default: r = HC_UNDEF;
      endcase
    end
    return r;
  endfunction

  always_comb begin
    class_o = classify(instr_i, arch_v6_i);
  end

endmodule

/* hw/rtl/arm_instruction_classifier_top.sv */
// ---------------------------------------------------------------------------
// Instruction classifier top level
// Classifies A32 instruction words into execution handler classes.
// ---------------------------------------------------------------------------
// Usage:
// Instruction words enter on the input channel (in_valid_i / in_ready_o,
// payload instruction_word_i); each word yields exactly one class word on
// the output channel (out_valid_o / out_ready_i, payload handler_class_o),
// in order.
// The word is captured in an input register, decoded by a shallow
// mask-and-compare network, and the class is captured in an output register,
// from which the receiver takes it.
// Throughput is one word per cycle while the receiver takes words: both
// register slices refill in the same cycle in which they drain, so
// back-to-back words flow without bubbles.
// When the receiver stalls, the output slice holds its word, the input slice
// fills behind it, and only then does in_ready_o fall.
// The configuration bit (cfg_we_i / cfg_wdata_i) selects whether movw/movt
// and the media group are decoded; the user must write it only while the
// block holds no words, and the block itself does not enforce this.
// Reset empties both slices and sets the configuration bit to one.
// ---------------------------------------------------------------------------
module arm_instruction_classifier_top import aic_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [InstrWidth-1:0] instruction_word_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [ClassWidth-1:0] handler_class_o
);

  // Architecture level register: one enables the v6-and-later encodings.
  logic arch_v6_d, arch_v6_q;

  assign arch_v6_d = cfg_we_i ? cfg_wdata_i : arch_v6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arch_v6_q <= 1'b1;
    end else begin
      arch_v6_q <= arch_v6_d;
    end
  end

  // Input slice holding the raw instruction word.
  logic                  instr_valid;
  logic                  instr_ready;
  logic [InstrWidth-1:0] instr_word;

  aic_stage #(
    .Width (InstrWidth)
  ) u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (instruction_word_i),
    .valid_o (instr_valid),
    .ready_i (instr_ready),
    .data_o  (instr_word)
  );

  // Combinational decode between the two slices.
  handler_class_e decoded_class;

  aic_decode u_decode (
    .instr_i   (instr_word),
    .arch_v6_i (arch_v6_q),
    .class_o   (decoded_class)
  );

  // Output slice holding the class until the receiver takes it.
  aic_stage #(
    .Width (ClassWidth)
  ) u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (instr_valid),
    .ready_o (instr_ready),
    .data_i  (ClassWidth'(decoded_class)),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (handler_class_o)
  );

endmodule

/* hw/rtl/aic_checker.sv */
// ---------------------------------------------------------------------------
// Instruction classifier checker
// Port-level assertions on the classifier, attached to the top by bind.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module aic_checker import aic_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [ClassWidth-1:0] handler_class_o
);

  logic in_fire;

  assign in_fire = in_valid_i && in_ready_o;

  // A stalled result word keeps its value.
  `ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
               out_valid_o && $stable(handler_class_o))

  // Only defined class codes ever leave the block.
  `ASSERT_IMPLY(a_class_range, out_valid_o, handler_class_o <= ClassWidth'(HC_RFE))

  // An accepted word guarantees a valid result word once it has passed the input slice.
  `ASSERT_IMPLY(a_latency, in_fire, ##2 out_valid_o)

  // Input backpressure only arises from a stalled output.
  `ASSERT_IMPLY(a_no_spurious_stall, !in_ready_o, out_valid_o && !out_ready_i)

endmodule

bind arm_instruction_classifier_top aic_checker u_aic_checker (.*);

/* sim/arm_instruction_classifier_top_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Instruction classifier testbench
// Streams A32 instruction words through the classifier and checks every
// class word against a predictor kept inside the bench. The words are a
// hand-picked set followed by shaped random words. The configuration bit
// is switched between phases. Both channels idle and stall at random.
// ---------------------------------------------------------------------------
module arm_instruction_classifier_top_tb;
  import aic_pkg::*;

  // Clock, reset and the pins of the block. Every input is known from time 0.
  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we = 1'b0;
  logic                  cfg_wdata = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [InstrWidth-1:0] in_word = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [ClassWidth-1:0] handler_class;

  // Words waiting to be offered, and the classes predicted for words the
  // block has already accepted, oldest first.
  logic [InstrWidth-1:0] pending_words[$];
  handler_class_e        predicted_classes[$];

  // Copy of the configuration bit as the block should hold it. Reset sets it.
  logic        v6_decode = 1'b1;
  // While set, neither side idles. This gives a long stretch at full rate.
  logic        calm = 1'b0;
  int unsigned error_count = 0;
  int unsigned words_sent = 0;
  int unsigned classes_checked = 0;

  arm_instruction_classifier_top dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we),
    .cfg_wdata_i        (cfg_wdata),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .instruction_word_i (in_word),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .handler_class_o    (handler_class)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // Predicts the handler class of one instruction word. The decode follows
  // the A32 tables: first the unconditional space, then bits 27:25, and
  // within each group the sub-tables.
  function automatic handler_class_e classify_word(input logic [31:0] w, input logic v6);
    logic [4:0] op1;
    logic [3:0] op2;
    logic [3:0] low_op1;
    logic [1:0] misc_op;
    logic [2:0] misc_sel;
    logic [2:0] media_op2;
    logic [6:0] hint_op;
    logic [7:0] uncond_op;
    logic [3:0] rn;
    op1       = w[24:20];
    op2       = w[7:4];
    low_op1   = w[23:20];
    misc_op   = w[22:21];
    misc_sel  = w[6:4];
    media_op2 = w[7:5];
    hint_op   = w[26:20];
    uncond_op = w[27:20];
    rn        = w[19:16];

    // Unconditional space with bit 27 clear: cps, setend, SIMD, hints,
    // barriers and preloads.
    if (w[31:27] == 5'b11110) begin
      if (hint_op == 7'h10) begin
        if (!op2[1] && !rn[0]) return HC_CPS;
        if (op2 == 4'h0 && rn[0]) return HC_UNIMPL;
        return HC_UNDEF;
      end
      if ((hint_op & 7'h60) == 7'h20) return HC_UNIMPL;
      if ((hint_op & 7'h71) == 7'h40) return HC_UNIMPL;
      if ((hint_op & 7'h77) == 7'h41) return HC_HINT;
      if ((hint_op & 7'h77) == 7'h45 || (hint_op & 7'h77) == 7'h51 ||
          (hint_op & 7'h77) == 7'h55) return HC_PRELOAD;
      if (hint_op == 7'h57) begin
        if (op2 == 4'h1 || op2 == 4'h4 || op2 == 4'h5 || op2 == 4'h6) return HC_HINT;
        return HC_UNDEF;
      end
      if ((hint_op & 7'h7B) == 7'h5B) return HC_HINT;
      if (!op2[0] && ((hint_op & 7'h77) == 7'h65 || (hint_op & 7'h77) == 7'h61 ||
                      (hint_op & 7'h77) == 7'h75)) return HC_PRELOAD;
      return HC_UNDEF;
    end

    // The rest of the unconditional space: srs, rfe, blx immediate and the
    // unconditional coprocessor forms.
    if (w[31:28] == 4'hF) begin
      if ((uncond_op & 8'hE5) == 8'h84) return HC_SRS;
      if ((uncond_op & 8'hE5) == 8'h81) return HC_RFE;
      if ((uncond_op & 8'hE0) == 8'hA0) return HC_BRANCH;
      if ((uncond_op & 8'hE0) == 8'hC0) return HC_UNIMPL;
      if ((uncond_op & 8'hF0) == 8'hE0) return HC_UNIMPL;
      return HC_UNDEF;
    end

    case (w[27:25])
      3'd0: begin
        // Miscellaneous group and halfword multiplies.
        if ((op1 & 5'h19) == 5'h10) begin
          if (op2[3]) return ((op2 & 4'h9) == 4'h8) ? HC_UNIMPL : HC_UNDEF;
          case (misc_sel)
            3'd0: begin
              if (w[9]) return HC_UNIMPL;
              if (!misc_op[0]) return HC_MRS;
              return (misc_op == 2'd1) ? HC_MSR : HC_UNDEF;
            end
            3'd1: begin
              if (misc_op == 2'd1) return HC_BX;
              return (misc_op == 2'd3) ? HC_CLZ : HC_UNDEF;
            end
            3'd2: return (misc_op == 2'd1) ? HC_UNIMPL : HC_UNDEF;
            3'd3: return (misc_op == 2'd1) ? HC_BX : HC_UNDEF;
            3'd5: return HC_UNIMPL;
            3'd6: return (misc_op == 2'd3) ? HC_UNIMPL : HC_UNDEF;
            3'd7: begin
              if (misc_op == 2'd1) return HC_BKPT;
              return (misc_op >= 2'd2) ? HC_UNIMPL : HC_UNDEF;
            end
            default: return HC_UNDEF;
          endcase
        end
        if (!op2[0] || (op2 & 4'h9) == 4'h1) return HC_DATA_PROC;
        // Multiplies, with umaal left unimplemented.
        if (!op1[4] && op2 == 4'h9) begin
          if ((low_op1 & 4'hE) == 4'h0 || (low_op1 & 4'hE) == 4'h2 || low_op1 == 4'h6)
            return HC_MUL;
          if (low_op1 == 4'h4) return HC_UNIMPL;
          if (low_op1[3]) return HC_MULL;
          return HC_UNDEF;
        end
        if (op2 == 4'h9) return ((low_op1 & 4'hB) == 4'h0) ? HC_SWAP : HC_EXCL;
        // Extra load/store. The unprivileged forms are not implemented.
        if ((op1 & 5'h13) == 5'h02 && (op2 & 4'hD) == 4'hD) return HC_EXTRA_LS;
        if ((op1 & 5'h12) == 5'h02 && op2 == 4'hB) return HC_UNIMPL;
        if ((op1 & 5'h13) == 5'h03 && (op2 & 4'hD) == 4'hD) return HC_UNIMPL;
        if (op2 == 4'hB || (op2 & 4'hD) == 4'hD) return HC_EXTRA_LS;
        return HC_UNDEF;
      end
      3'd1: begin
        if (op1 == 5'h12 || op1 == 5'h16) return HC_MSR;
        // movw and movt exist only from v6 on.
        if (op1 == 5'h10 || op1 == 5'h14) return v6 ? HC_DATA_PROC : HC_UNDEF;
        return HC_DATA_PROC;
      end
      3'd2: return HC_LOAD_STORE;
      3'd3: begin
        if (!w[4]) return HC_LOAD_STORE;
        if (!v6) return HC_UNDEF;
        case (op1[4:3])
          2'd0: return HC_UNIMPL;
          2'd1: begin
            // Packing, unpacking, saturation and reversal.
            case (w[22:20])
              3'd0: begin
                if (!media_op2[0]) return HC_UNIMPL;
                if (media_op2 == 3'd3) return HC_EXTEND;
                return (media_op2 == 3'd5) ? HC_UNIMPL : HC_UNDEF;
              end
              3'd2, 3'd6: begin
                if (media_op2 == 3'd1) return HC_UNIMPL;
                if (media_op2 == 3'd3) return HC_EXTEND;
                return (!media_op2[0]) ? HC_UNIMPL : HC_UNDEF;
              end
              3'd3, 3'd7: begin
                if (media_op2 == 3'd1 || media_op2 == 3'd5) return HC_UNIMPL;
                if (media_op2 == 3'd3) return HC_EXTEND;
                return (!media_op2[0]) ? HC_UNIMPL : HC_UNDEF;
              end
              3'd4: return (media_op2 == 3'd3) ? HC_EXTEND : HC_UNDEF;
              default: return HC_UNDEF;
            endcase
          end
          2'd2: return HC_UNIMPL;
          default: begin
            if (op1 == 5'h18 && media_op2 == 3'd0) return HC_UNIMPL;
            if ((op1 & 5'h1A) == 5'h1A && media_op2[1:0] == 2'd2) return HC_BITFIELD;
            if ((op1 & 5'h1E) == 5'h1C && media_op2[1:0] == 2'd0) return HC_UNIMPL;
            // The permanently undefined encoding.
            if (op1 == 5'h1F && media_op2 == 3'd7) return HC_UNDEF;
            return HC_UNIMPL;
          end
        endcase
      end
      3'd4: return HC_LS_MULTI;
      3'd5: return HC_BRANCH;
      3'd6: begin
        if (w[24:23] == 2'd0 && !w[21]) return w[22] ? HC_MCRR : HC_UNDEF;
        return HC_COP_LS;
      end
      default: begin
        if (w[24]) return HC_SWI;
        return w[4] ? HC_COP_REG : HC_COP_DP;
      end
    endcase
    return HC_UNDEF;
  endfunction

  // Random instruction words. Most are aimed at one decode group with the
  // rest of their bits random, so that every sub-table is reached often.
  // One in ten is fully random.
  function automatic logic [31:0] random_instruction();
    logic [31:0] w;
    logic [3:0]  cond;
    int          group;
    w     = $urandom();
    cond  = 4'($urandom_range(14));
    group = $urandom_range(9);
    case (group)
      0: ;
      1: begin
        w[31:28] = cond;
        w[27:25] = 3'b000;
      end
      2: begin
        // Miscellaneous group and halfword multiplies.
        w[31:28] = cond;
        w[27:23] = 5'b00010;
        w[20]    = 1'b0;
      end
      3: begin
        w[31:28] = cond;
        w[27:25] = 3'b011;
        w[4]     = 1'b1;
      end
      4: begin
        w[31:28] = cond;
        w[27:25] = 3'b001;
      end
      5: begin
        w[31:28] = 4'hE;
        w[27:25] = 3'($urandom_range(7, 2));
      end
      6: begin
        w[31:27] = 5'b11110;
        if ($urandom_range(2) == 0) w[26:20] = $urandom_range(1) ? 7'h10 : 7'h57;
      end
      7: begin
        w[31:28] = 4'hF;
        w[27]    = 1'b1;
      end
      default: begin
        // Multiplies, synchronization and extra load/store.
        w[31:28] = cond;
        w[27:25] = 3'b000;
        w[7]     = 1'b1;
        w[4]     = 1'b1;
      end
    endcase
    return w;
  endfunction

  // Driver. A word that has been offered stays on the pins until the block
  // takes it. When the channel is free, the next pending word goes out
  // unless this cycle idles. The predicted class is queued when the
  // handshake completes. At that point the configuration cannot be changing.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        predicted_classes.push_back(classify_word(in_word, v6_decode));
        words_sent++;
      end
      if (!in_valid || in_ready) begin
        if (pending_words.size() != 0 && (calm || $urandom_range(99) >= 6)) begin
          in_word  <= pending_words.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Each class word taken from the block is checked against the
  // oldest prediction. The ready for the next cycle stalls now and then.
  always @(posedge clk_i) begin : monitor
    handler_class_e want;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        classes_checked++;
        if (predicted_classes.size() == 0) begin
          report_mismatch($sformatf("class word %0d with no instruction outstanding",
                                    handler_class));
        end else begin
          want = predicted_classes.pop_front();
          if (handler_class !== want)
            report_mismatch($sformatf("class %0d, expected %0d (%s)",
                                      handler_class, want, want.name()));
        end
      end
      out_ready <= calm || ($urandom_range(99) >= 6);
    end
  end

  // Waits until every word has been offered, taken and answered.
  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid || predicted_classes.size() != 0)
      @(posedge clk_i);
  endtask

  // Writes the configuration bit once the block is empty. Every word
  // yields a class word, so an empty block is one whose predictions have
  // all been answered.
  task automatic write_config(input logic value);
    wait_drained();
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    v6_decode  = value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic queue_random(input int count);
    for (int i = 0; i < count; i++) pending_words.push_back(random_instruction());
  endtask

  initial begin : stimulus
    logic [31:0] directed_words [39];
    // One word for each class but swap, and for each special case: banked
    // mrs, bxj, saturating add, smc, halfword multiply, umaal, unprivileged
    // halfword load, the permanently undefined media word, movw, setend,
    // SIMD, the unconditional coprocessor space and an unlisted
    // unconditional word. The two extremes of the word are included.
    directed_words = '{
      32'h0000_0000, 32'hFFFF_FFFF, 32'hE10F_0000, 32'hE10F_0200, 32'hE129_F000,
      32'hE12F_FF1E, 32'hE16F_0F11, 32'hE120_0070, 32'hE12F_FF20, 32'hE101_0050,
      32'hE160_0070, 32'hE100_0080, 32'hE000_0091, 32'hE040_0091, 32'hE080_0091,
      32'hE190_0F9F, 32'hE1D0_00B0, 32'hE030_00B0, 32'hE590_0000, 32'hE6AF_0070,
      32'hE7E0_0050, 32'hE7F0_00F0, 32'hE300_0000, 32'hE8BD_8000, 32'hEA00_0000,
      32'hEC40_0000, 32'hED90_0000, 32'hEE00_0010, 32'hEE00_0000, 32'hEF00_0000,
      32'hF108_0000, 32'hF101_0000, 32'hF200_0000, 32'hF57F_F05F, 32'hF5D0_F000,
      32'hF84D_0500, 32'hF890_0A00, 32'hFA00_0000, 32'hFC00_0000
    };

    // Reset is held low from time 0 and never asserted again.
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Phase 1: v6 decode on, the directed words.
    write_config(1'b1);
    foreach (directed_words[i]) pending_words.push_back(directed_words[i]);

    // Phase 2: v6 decode off. Media and movw words must turn undefined.
    write_config(1'b0);
    foreach (directed_words[i]) pending_words.push_back(directed_words[i]);
    queue_random(100);

    // Phase 3: v6 decode back on, with random idling on both sides.
    write_config(1'b1);
    queue_random(75);

    // Phase 4: no idling at all, so back-to-back words stream through.
    wait_drained();
    calm = 1'b1;
    queue_random(100);
    wait_drained();
    calm = 1'b0;

    // Phase 5: v6 decode off again.
    write_config(1'b0);
    queue_random(100);

    // Let the pipeline settle so that a stray class word is still caught.
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (predicted_classes.size() != 0)
      report_mismatch($sformatf("%0d class words never arrived", predicted_classes.size()));

    $display("Classified %0d instruction words and checked %0d class words,",
             words_sent, classes_checked);
    $display("with v6 decode both on and off and with idle and full-rate phases.");
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // A hang ends here.
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/aic_pkg.sv
hw/rtl/aic_stage.sv
hw/rtl/aic_decode.sv
hw/rtl/arm_instruction_classifier_top.sv
hw/rtl/aic_checker.sv
sim/arm_instruction_classifier_top_tb.sv
